// ===== sv/esrs_pkg.sv =====
// ----------------------------------------------------------------------------
// esrs_pkg
// Shared types, register addresses and constant tables for the sensor
// register slave.
// ----------------------------------------------------------------------------
package esrs_pkg;

    localparam int OP_W       = 3;
    localparam int BYTE_W     = 8;
    localparam int PTR_W      = 16;
    localparam int IDX_W      = 5;
    localparam int TABLE_ROWS = 24;
    localparam int SAMPLE_COUNT = 24;   // table entries cycled by the tick, 0..23
    localparam int IN_TDATA_W  = 16;    // op (3) + data_byte (8), padded
    localparam int OUT_TDATA_W = 16;    // read_data (8) + ack (1), padded

    typedef enum logic [OP_W-1:0] {
        OP_WR_START = 3'd0,
        OP_RD_START = 3'd1,
        OP_WR_BYTE  = 3'd2,
        OP_RD_BYTE  = 3'd3,
        OP_TICK     = 3'd4
    } op_t;

    // register map
    localparam logic [PTR_W-1:0] ADDR_CHIP_ID     = 16'h00D0;
    localparam logic [PTR_W-1:0] ADDR_ROM_LO_FIRST = 16'h0088;
    localparam logic [PTR_W-1:0] ADDR_ROM_LO_LAST  = 16'h00A1;
    localparam logic [PTR_W-1:0] ADDR_ROM_HI_FIRST = 16'h00E1;
    localparam logic [PTR_W-1:0] ADDR_ROM_HI_LAST  = 16'h00E7;
    localparam logic [PTR_W-1:0] ADDR_HUM_CTRL    = 16'h00F2;
    localparam logic [PTR_W-1:0] ADDR_STATUS      = 16'h00F3;
    localparam logic [PTR_W-1:0] ADDR_MEAS_CTRL   = 16'h00F4;
    localparam logic [PTR_W-1:0] ADDR_CONFIG      = 16'h00F5;
    localparam logic [PTR_W-1:0] ADDR_SAMPLE_FIRST = 16'h00F7;
    localparam logic [PTR_W-1:0] ADDR_SAMPLE_LAST  = 16'h00FE;

    localparam logic [BYTE_W-1:0] CHIP_ID        = 8'h60;
    localparam logic [BYTE_W-1:0] HUM_CTRL_RST   = 8'h01;
    localparam logic [BYTE_W-1:0] MEAS_CTRL_RST  = 8'h27;
    localparam logic [BYTE_W-1:0] CONFIG_RST     = 8'h00;

    typedef struct packed {
        logic [BYTE_W-1:0] hum_ctrl;
        logic [BYTE_W-1:0] meas_ctrl;
        logic [BYTE_W-1:0] config_byte;
    } ctrl_regs_t;

    localparam logic [BYTE_W-1:0] ROM_LO [0:25] = '{
        8'd112, 8'd107, 8'd67,  8'd103, 8'd24,  8'd252,
        8'd125, 8'd142, 8'd67,  8'd214, 8'd208, 8'd11,  8'd39, 8'd11,
        8'd140, 8'd0,   8'd249, 8'd255, 8'd140, 8'd60,  8'd56, 8'd199,
        8'd112, 8'd23,  8'd0,   8'd75
    };

    localparam logic [BYTE_W-1:0] ROM_HI [0:6] = '{
        8'd116, 8'd1, 8'd0, 8'd17, 8'd42, 8'd3, 8'd30
    };

    localparam logic [19:0] RAW_TEMP [0:TABLE_ROWS-1] = '{
        20'd467223, 20'd463687, 20'd461464, 20'd460706, 20'd461464, 20'd463687,
        20'd467223, 20'd471833, 20'd477204, 20'd482970, 20'd488738, 20'd494115,
        20'd498735, 20'd502280, 20'd504510, 20'd505270, 20'd504510, 20'd502280,
        20'd498735, 20'd494115, 20'd488738, 20'd482970, 20'd477204, 20'd471833
    };

    localparam logic [19:0] RAW_PRESS [0:TABLE_ROWS-1] = '{
        20'd396819, 20'd394881, 20'd393568, 20'd393102, 20'd393568, 20'd394881,
        20'd396819, 20'd399066, 20'd401286, 20'd403199, 20'd404629, 20'd405532,
        20'd405978, 20'd406116, 20'd406112, 20'd406095, 20'd406112, 20'd406116,
        20'd405978, 20'd405532, 20'd404629, 20'd403199, 20'd401286, 20'd399066
    };

    localparam logic [15:0] RAW_HUM [0:TABLE_ROWS-1] = '{
        16'd32768, 16'd33197, 16'd33469, 16'd33562, 16'd33469, 16'd33197,
        16'd32768, 16'd32211, 16'd31569, 16'd30887, 16'd30210, 16'd29586,
        16'd29055, 16'd28650, 16'd28396, 16'd28310, 16'd28396, 16'd28650,
        16'd29055, 16'd29586, 16'd30210, 16'd30887, 16'd31569, 16'd32211
    };

endpackage

// ===== sv/esrs_reg_read.sv =====
// ----------------------------------------------------------------------------
// esrs_reg_read
// Read-side address decode: returns the byte at the register pointer.
// ----------------------------------------------------------------------------
module esrs_reg_read
    import esrs_pkg::*;
(
    input  logic [PTR_W-1:0]  pointer,
    input  ctrl_regs_t        ctrl,
    input  logic [IDX_W-1:0]  sample_index,
    output logic [BYTE_W-1:0] read_data
);

    logic [PTR_W-1:0] lo_off;
    logic [PTR_W-1:0] hi_off;
    logic [PTR_W-1:0] smp_off;
    logic [19:0]      press;
    logic [19:0]      temp;
    logic [15:0]      hum;
    logic [BYTE_W-1:0] sample_byte;

    assign lo_off  = pointer - ADDR_ROM_LO_FIRST;
    assign hi_off  = pointer - ADDR_ROM_HI_FIRST;
    assign smp_off = pointer - ADDR_SAMPLE_FIRST;

    always_comb
    begin
        press = '0;
        temp  = '0;
        hum   = '0;
        if (32'(sample_index) < TABLE_ROWS)
        begin
            press = RAW_PRESS[sample_index];
            temp  = RAW_TEMP[sample_index];
            hum   = RAW_HUM[sample_index];
        end
    end

    // 20-bit values go out MSB first, last byte left-aligned in the upper nibble
    always_comb
    begin
        case (smp_off[2:0])
            3'd0:    sample_byte = press[19:12];
            3'd1:    sample_byte = press[11:4];
            3'd2:    sample_byte = {press[3:0], 4'b0000};
            3'd3:    sample_byte = temp[19:12];
            3'd4:    sample_byte = temp[11:4];
            3'd5:    sample_byte = {temp[3:0], 4'b0000};
            3'd6:    sample_byte = hum[15:8];
            default: sample_byte = hum[7:0];
        endcase
    end

    always_comb
    begin
        if (pointer == ADDR_CHIP_ID)
            read_data = CHIP_ID;
        else if (pointer inside {[ADDR_ROM_LO_FIRST:ADDR_ROM_LO_LAST]})
            read_data = ROM_LO[lo_off[4:0]];
        else if (pointer inside {[ADDR_ROM_HI_FIRST:ADDR_ROM_HI_LAST]})
            read_data = ROM_HI[hi_off[2:0]];
        else if (pointer == ADDR_HUM_CTRL)
            read_data = ctrl.hum_ctrl;
        else if (pointer == ADDR_STATUS)
            read_data = '0;
        else if (pointer == ADDR_MEAS_CTRL)
            read_data = ctrl.meas_ctrl;
        else if (pointer == ADDR_CONFIG)
            read_data = ctrl.config_byte;
        else if (pointer inside {[ADDR_SAMPLE_FIRST:ADDR_SAMPLE_LAST]})
            read_data = sample_byte;
        else
            read_data = '0;
    end

endmodule

// ===== sv/environment_sensor_register_slave_top.sv =====
// ----------------------------------------------------------------------------
// environment_sensor_register_slave_top
// Byte-level register side of an environmental sensor bus slave.
// ----------------------------------------------------------------------------
// The result of an accepted item is registered and shows on the output stream in the next cycle.
// Throughput: one item per cycle; the output register takes a new result
// whenever it is empty or being drained in the same cycle.
// Reset: pointer and pending flag cleared, control registers at their
// defaults, sample index zero, output stream empty.
module environment_sensor_register_slave_top
    import esrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [2:0] op, [10:3] data_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [7:0] read_data, [8] ack
);

    logic [PTR_W-1:0]  pointer_reg,  pointer_next;
    logic              pending_reg,  pending_next;
    ctrl_regs_t        ctrl_reg,     ctrl_next;
    logic [IDX_W-1:0]  index_reg,    index_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic              out_ack_reg,  out_ack_next;

    logic              accept;
    op_t               op;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] rd_byte;
    logic [IDX_W:0]    index_inc;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign op        = op_t'(s_tdata[OP_W-1:0]);
    assign data_byte = s_tdata[OP_W +: BYTE_W];
    assign index_inc = {1'b0, index_reg} + (IDX_W+1)'(1);

    esrs_reg_read u_read
    (
        .pointer      (pointer_reg),
        .ctrl         (ctrl_reg),
        .sample_index (index_reg),
        .read_data    (rd_byte)
    );

    always_comb
    begin
        pointer_next   = pointer_reg;
        pending_next   = pending_reg;
        ctrl_next      = ctrl_reg;
        index_next     = index_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_ack_next   = out_ack_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_ack_next   = 1'b1;
            case (op)
                OP_WR_START:
                    pending_next = 1'b1;
                OP_RD_START:
                    ;
                OP_WR_BYTE:
                begin
                    if (pending_reg)
                    begin
                        // first byte after a write start loads the pointer
                        pointer_next = PTR_W'(data_byte);
                        pending_next = 1'b0;
                    end
                    else
                    begin
                        if (pointer_reg == ADDR_HUM_CTRL)
                            ctrl_next.hum_ctrl = data_byte;
                        else if (pointer_reg == ADDR_MEAS_CTRL)
                            ctrl_next.meas_ctrl = data_byte;
                        else if (pointer_reg == ADDR_CONFIG)
                            ctrl_next.config_byte = data_byte;
                        pointer_next = pointer_reg + PTR_W'(1);
                    end
                end
                OP_RD_BYTE:
                begin
                    out_data_next = rd_byte;
                    pointer_next  = pointer_reg + PTR_W'(1);
                end
                OP_TICK:
                begin
                    out_ack_next = 1'b0;
                    if (32'(index_inc) >= SAMPLE_COUNT)
                        index_next = '0;
                    else
                        index_next = index_inc[IDX_W-1:0];
                end
                default:
                    out_ack_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_reg           <= '0;
            pending_reg           <= 1'b0;
            ctrl_reg.hum_ctrl     <= HUM_CTRL_RST;
            ctrl_reg.meas_ctrl    <= MEAS_CTRL_RST;
            ctrl_reg.config_byte  <= CONFIG_RST;
            index_reg             <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            pointer_reg   <= pointer_next;
            pending_reg   <= pending_next;
            ctrl_reg      <= ctrl_next;
            index_reg     <= index_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_ack_reg  <= out_ack_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W-BYTE_W-1)'(0), out_ack_reg, out_data_reg};

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the sensor register slave. Bus items are fed from a
// queue through a clocked driver; a clocked monitor predicts the reply to
// every accepted item and compares each returned reply against the oldest
// prediction. Covers directed corner cases, random register transactions,
// a pointer walk past the 8-bit address space, random idling and
// back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_top
    import esrs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // op codes the block does not decode
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [BYTE_W-1:0] ID_BYTE     = 8'h60;
    localparam logic [BYTE_W-1:0] HUM_DEFAULT = 8'h01;
    localparam logic [BYTE_W-1:0] MEAS_DEFAULT = 8'h27;
    localparam logic [BYTE_W-1:0] CFG_DEFAULT = 8'h00;

    localparam int RANDOM_ITEMS   = 1450;
    localparam int WALK_ITEMS     = 40;
    localparam logic [BYTE_W-1:0] WALK_START = 8'hF0;
    localparam int GAP_LONG_MAX   = 30;
    localparam int STALL_LONG_MAX = 30;
    localparam int HOLD_CYCLES    = 150;
    localparam int HOLD_FIRST     = 300;
    localparam int HOLD_SECOND    = 1100;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_REPORTS    = 100;

    localparam logic [BYTE_W-1:0] CAL_LOW [0:25] = '{
        8'd112, 8'd107, 8'd67,  8'd103, 8'd24,  8'd252,
        8'd125, 8'd142, 8'd67,  8'd214, 8'd208, 8'd11,  8'd39, 8'd11,
        8'd140, 8'd0,   8'd249, 8'd255, 8'd140, 8'd60,  8'd56, 8'd199,
        8'd112, 8'd23,  8'd0,   8'd75
    };
    localparam logic [BYTE_W-1:0] CAL_HIGH [0:6] = '{
        8'd116, 8'd1, 8'd0, 8'd17, 8'd42, 8'd3, 8'd30
    };
    localparam logic [19:0] TEMP_ROWS [0:23] = '{
        20'd467223, 20'd463687, 20'd461464, 20'd460706, 20'd461464, 20'd463687,
        20'd467223, 20'd471833, 20'd477204, 20'd482970, 20'd488738, 20'd494115,
        20'd498735, 20'd502280, 20'd504510, 20'd505270, 20'd504510, 20'd502280,
        20'd498735, 20'd494115, 20'd488738, 20'd482970, 20'd477204, 20'd471833
    };
    localparam logic [19:0] PRESS_ROWS [0:23] = '{
        20'd396819, 20'd394881, 20'd393568, 20'd393102, 20'd393568, 20'd394881,
        20'd396819, 20'd399066, 20'd401286, 20'd403199, 20'd404629, 20'd405532,
        20'd405978, 20'd406116, 20'd406112, 20'd406095, 20'd406112, 20'd406116,
        20'd405978, 20'd405532, 20'd404629, 20'd403199, 20'd401286, 20'd399066
    };
    localparam logic [15:0] HUM_ROWS [0:23] = '{
        16'd32768, 16'd33197, 16'd33469, 16'd33562, 16'd33469, 16'd33197,
        16'd32768, 16'd32211, 16'd31569, 16'd30887, 16'd30210, 16'd29586,
        16'd29055, 16'd28650, 16'd28396, 16'd28310, 16'd28396, 16'd28650,
        16'd29055, 16'd29586, 16'd30210, 16'd30887, 16'd31569, 16'd32211
    };

    // addresses worth aiming the pointer at: map edges and their neighbours
    localparam logic [PTR_W-1:0] HOT_ADDR [0:13] = '{
        ADDR_CHIP_ID, ADDR_ROM_LO_FIRST, ADDR_ROM_LO_FIRST - 16'd1,
        ADDR_ROM_LO_LAST, ADDR_ROM_LO_LAST - 16'd2, ADDR_ROM_HI_FIRST - 16'd1,
        ADDR_ROM_HI_FIRST, ADDR_ROM_HI_LAST, ADDR_HUM_CTRL, ADDR_STATUS,
        ADDR_MEAS_CTRL, ADDR_CONFIG, ADDR_SAMPLE_FIRST, ADDR_SAMPLE_LAST
    };

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic              drain;   // hold this item until no reply is outstanding
        logic              steady;  // no sender gap after this item
    } bus_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              ack;
    } sensor_reply_t;

    logic clk;
    logic rst_n;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [2:0] op, [10:3] data_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [7:0] read_data, [8] ack

    environment_sensor_register_slave_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bus_item_t     pending_items[$];
    sensor_reply_t expected_replies[$];

    // predicted slave state
    logic [PTR_W-1:0]  reg_ptr     = '0;
    logic              ptr_armed   = 1'b0;
    logic [BYTE_W-1:0] hum_ctrl    = HUM_DEFAULT;
    logic [BYTE_W-1:0] meas_ctrl   = MEAS_DEFAULT;
    logic [BYTE_W-1:0] cfg_reg     = CFG_DEFAULT;
    logic [IDX_W-1:0]  tick_index  = '0;

    int    error_count    = 0;
    int    items_accepted = 0;
    int    replies_seen   = 0;
    int    useful_items   = 0;
    int    total_items    = 0;
    bit    in_accepted    = 1'b0;
    int    gap_left       = 0;
    longint cycle_count   = 0;
    longint cycle_limit   = 64'd1000000;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [BYTE_W-1:0] register_value(input logic [PTR_W-1:0] addr);
        logic [19:0]      p;
        logic [19:0]      t;
        logic [15:0]      h;
        logic [PTR_W-1:0] off;
        register_value = '0;
        if (addr == ADDR_CHIP_ID)
            register_value = ID_BYTE;
        else if (addr >= ADDR_ROM_LO_FIRST && addr <= ADDR_ROM_LO_LAST)
            register_value = CAL_LOW[addr - ADDR_ROM_LO_FIRST];
        else if (addr >= ADDR_ROM_HI_FIRST && addr <= ADDR_ROM_HI_LAST)
            register_value = CAL_HIGH[addr - ADDR_ROM_HI_FIRST];
        else if (addr == ADDR_HUM_CTRL)
            register_value = hum_ctrl;
        else if (addr == ADDR_MEAS_CTRL)
            register_value = meas_ctrl;
        else if (addr == ADDR_CONFIG)
            register_value = cfg_reg;
        else if (addr >= ADDR_SAMPLE_FIRST && addr <= ADDR_SAMPLE_LAST
                 && int'(tick_index) < TABLE_ROWS)
        begin
            p   = PRESS_ROWS[tick_index];
            t   = TEMP_ROWS[tick_index];
            h   = HUM_ROWS[tick_index];
            off = addr - ADDR_SAMPLE_FIRST;
            case (off)
                16'd0:   register_value = p[19:12];
                16'd1:   register_value = p[11:4];
                16'd2:   register_value = {p[3:0], 4'h0};
                16'd3:   register_value = t[19:12];
                16'd4:   register_value = t[11:4];
                16'd5:   register_value = {t[3:0], 4'h0};
                16'd6:   register_value = h[15:8];
                default: register_value = h[7:0];
            endcase
        end
        // status and unmapped addresses read as zero
    endfunction

    task automatic predict_reply(input logic [OP_W-1:0] opc, input logic [BYTE_W-1:0] din);
        sensor_reply_t r;
        r.read_data = '0;
        r.ack       = 1'b1;
        case (opc)
            OP_WR_START:
                ptr_armed = 1'b1;
            OP_RD_START:
            begin
            end
            OP_WR_BYTE:
                if (ptr_armed)
                begin
                    reg_ptr   = {8'h00, din};
                    ptr_armed = 1'b0;
                end
                else
                begin
                    if (reg_ptr == ADDR_HUM_CTRL)
                        hum_ctrl = din;
                    else if (reg_ptr == ADDR_MEAS_CTRL)
                        meas_ctrl = din;
                    else if (reg_ptr == ADDR_CONFIG)
                        cfg_reg = din;
                    reg_ptr = reg_ptr + 16'd1;
                end
            OP_RD_BYTE:
            begin
                r.read_data = register_value(reg_ptr);
                reg_ptr     = reg_ptr + 16'd1;
            end
            OP_TICK:
            begin
                if (int'(tick_index) + 1 >= SAMPLE_COUNT)
                    tick_index = '0;
                else
                    tick_index = tick_index + 1'b1;
                r.ack = 1'b0;
            end
            default:
                r.ack = 1'b0;
        endcase
        expected_replies.push_back(r);
    endtask

    task automatic note_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (error_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, field, want, got);
        error_count++;
    endtask

    task automatic check_reply(input logic [OUT_TDATA_W-1:0] got);
        sensor_reply_t want;
        if (expected_replies.size() == 0)
        begin
            note_mismatch("unexpected reply", 16'h0, got);
        end
        else
        begin
            want = expected_replies.pop_front();
            if (got[7:0] !== want.read_data)
                note_mismatch("read_data", 16'(want.read_data), 16'(got[7:0]));
            if (got[8] !== want.ack)
                note_mismatch("ack", 16'(want.ack), 16'(got[8]));
            if (got[OUT_TDATA_W-1:9] !== '0)
                note_mismatch("padding", 16'h0, 16'(got[OUT_TDATA_W-1:9]));
        end
    endtask

    // output side checked before the new input is predicted, so a spurious
    // reply never consumes the prediction made in the same cycle
    always @(posedge clk)
    begin : monitor
        in_accepted = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_reply(m_tdata);
                replies_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                predict_reply(s_tdata[2:0], s_tdata[10:3]);
                items_accepted++;
                in_accepted = 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            pick_gap = 0;
        else if (r < 95)
            pick_gap = $urandom_range(1, 3);
        else
            pick_gap = $urandom_range(10, GAP_LONG_MAX);
    endfunction

    always @(negedge clk)
    begin : driver
        bus_item_t             head;
        logic                  valid_nxt;
        logic [IN_TDATA_W-1:0] data_nxt;
        valid_nxt = s_tvalid;
        data_nxt  = s_tdata;
        if (!rst_n)
            valid_nxt = 1'b0;
        else if (!s_tvalid || in_accepted)
        begin
            valid_nxt = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_items.size() > 0
                     && (!pending_items[0].drain || expected_replies.size() == 0))
            begin
                head      = pending_items.pop_front();
                valid_nxt = 1'b1;
                data_nxt  = IN_TDATA_W'({head.data, head.op});
                gap_left  = head.steady ? 0 : pick_gap();
            end
        end
        s_tvalid <= valid_nxt;
        s_tdata  <= data_nxt;
    end

    always @(negedge clk)
    begin : receiver
        int   r;
        int   hold_left;
        int   stall_left;
        int   calm_left;
        int   holds_done;
        logic ready_nxt;
        ready_nxt = 1'b1;
        if (!rst_n)
        begin
            ready_nxt  = 1'b0;
            hold_left  = 0;
            stall_left = 0;
            calm_left  = 0;
            holds_done = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            ready_nxt = 1'b0;
        end
        else if (holds_done < 2
                 && replies_seen >= (holds_done == 0 ? HOLD_FIRST : HOLD_SECOND))
        begin
            // long hold-off: output register fills and the input stalls
            hold_left = HOLD_CYCLES - 1;
            holds_done++;
            ready_nxt = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            ready_nxt = 1'b0;
        end
        else if (calm_left > 0)
            calm_left--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                calm_left = $urandom_range(40, 200);
            else if (r >= 80 && r < 96)
            begin
                stall_left = $urandom_range(1, 3) - 1;
                ready_nxt  = 1'b0;
            end
            else if (r >= 96)
            begin
                stall_left = $urandom_range(10, STALL_LONG_MAX) - 1;
                ready_nxt  = 1'b0;
            end
        end
        m_tready <= ready_nxt;
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                              input bit drain = 1'b0, input bit steady = 1'b0);
        bus_item_t it;
        it.op     = op;
        it.data   = data;
        it.drain  = drain;
        it.steady = steady;
        pending_items.push_back(it);
        if (op <= OP_TICK)
            useful_items++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_address();
        if ($urandom_range(0, 99) < 40)
            pick_address = BYTE_W'($urandom_range(0, 255));
        else
            pick_address = HOT_ADDR[$urandom_range(0, 13)][BYTE_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            pick_data = 8'hFF;
        else if (r < 20)
            pick_data = 8'h00;
        else
            pick_data = BYTE_W'($urandom_range(0, 255));
    endfunction

    initial
    begin : stimulus
        int  r;
        int  n;
        int  random_start;
        bit  drain;
        bit  steady;

        // read at the reset pointer: unmapped, reads zero
        queue_item(OP_RD_BYTE, 8'h00);
        // control registers and status at their defaults
        queue_item(OP_WR_START, 8'h00);
        queue_item(OP_WR_BYTE, ADDR_HUM_CTRL[7:0]);
        repeat (4) queue_item(OP_RD_BYTE, 8'h00);
        // write extremes to each control register; the status write is dropped
        queue_item(OP_WR_START, 8'h00);
        queue_item(OP_WR_BYTE, ADDR_HUM_CTRL[7:0]);
        queue_item(OP_WR_BYTE, 8'hFF);
        queue_item(OP_WR_BYTE, 8'hFF);
        queue_item(OP_WR_BYTE, 8'h00);
        queue_item(OP_WR_BYTE, 8'hFF);
        // soft-reset address takes the write like any unmapped one
        queue_item(OP_WR_START, 8'h00);
        queue_item(OP_WR_BYTE, ADDR_ROM_HI_FIRST[7:0] - 8'd1);
        queue_item(OP_WR_BYTE, 8'hB6);
        queue_item(OP_RD_BYTE, 8'h00);
        // read-direction start, then a read while the pointer is still armed
        queue_item(OP_RD_START, 8'h00);
        queue_item(OP_WR_START, 8'h00);
        queue_item(OP_RD_BYTE, 8'h00);
        queue_item(OP_WR_BYTE, ADDR_SAMPLE_LAST[7:0] - 8'd1);
        repeat (4) queue_item(OP_RD_BYTE, 8'h00);
        queue_item(OP_TICK, 8'hFF);
        queue_item(OP_SPARE_FIRST, 8'hFF);
        queue_item(OP_SPARE_LAST, 8'h00);

        random_start = useful_items;
        while (useful_items - random_start < RANDOM_ITEMS)
        begin
            r      = $urandom_range(0, 99);
            drain  = ($urandom_range(0, 99) < 5);
            steady = ($urandom_range(0, 99) < 15);
            if (r < 30)
            begin
                queue_item(OP_WR_START, BYTE_W'($urandom_range(0, 255)), drain, steady);
                queue_item(OP_WR_BYTE, pick_address(), 1'b0, steady);
                n = $urandom_range(0, 4);
                repeat (n) queue_item(OP_WR_BYTE, pick_data(), 1'b0, steady);
            end
            else if (r < 65)
            begin
                queue_item(OP_WR_START, BYTE_W'($urandom_range(0, 255)), drain, steady);
                queue_item(OP_WR_BYTE, pick_address(), 1'b0, steady);
                queue_item(OP_RD_START, BYTE_W'($urandom_range(0, 255)), 1'b0, steady);
                n = $urandom_range(1, 9);
                repeat (n)
                    queue_item(OP_RD_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b0, steady);
            end
            else if (r < 75)
            begin
                queue_item(OP_RD_START, BYTE_W'($urandom_range(0, 255)), drain, steady);
                n = $urandom_range(1, 4);
                repeat (n)
                    queue_item(OP_RD_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b0, steady);
            end
            else if (r < 83)
            begin
                n = $urandom_range(1, 30);
                repeat (n)
                    queue_item(OP_TICK, BYTE_W'($urandom_range(0, 255)), drain, steady);
            end
            else
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    queue_item(OP_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
                               drain, steady);
            end
        end

        // pointer walk from the top of the byte map past 0xFF: writes above
        // the 8-bit map must be dropped and reads there return zero
        queue_item(OP_WR_START, 8'h00, 1'b1);
        queue_item(OP_WR_BYTE, WALK_START);
        for (int i = 0; i < WALK_ITEMS; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                queue_item(OP_WR_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
            else
                queue_item(OP_RD_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        repeat (2) queue_item(OP_RD_BYTE, 8'h00);

        total_items = pending_items.size();
        cycle_limit = 4 * (longint'(total_items) * (GAP_LONG_MAX + STALL_LONG_MAX + 2)
                      + 2 * HOLD_CYCLES) + 1000;

        while (items_accepted < total_items || expected_replies.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
